// ----- src/hufd_pkg.sv -----
`default_nettype none

package hufd_pkg;

    localparam int SYM_BITS  = 8;
    localparam int MAX_NODES = 255;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int VAL_W     = (SYM_BITS > NODE_W) ? SYM_BITS : NODE_W;
    localparam int BL_W      = $clog2(SYM_BITS + 1);
    localparam int USED_W    = 9;
    localparam int ALIGN_W   = 3;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int LIMIT_W   = 9;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 9'd511;
    localparam logic [REG_IDX_W-1:0] REG_NODE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        KIND_SYMBOL = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_BAD    = 2'd2
    } t_kind;

    // child reference: leaf flag plus symbol or node index
    typedef struct packed {
        logic             leaf;
        logic [VAL_W-1:0] val;
    } t_ref;

    typedef struct packed {
        t_ref c1;
        t_ref c0;
    } t_entry;

    // open parent: node index, second slot pending, first child held until node closes
    typedef struct packed {
        logic [NODE_W-1:0] idx;
        logic              second;
        t_ref              first;
    } t_stk;

    typedef struct packed {
        logic data_bit;
        logic new_tree;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        t_kind               kind;
    } t_result;

endpackage

`default_nettype wire

// ----- src/huffman_tree_load_and_decode.sv -----
`default_nettype none

// Channel   Direction  Handshake           Beat
// input     in         i_valid / o_stall   i_data_bit, i_new_tree
// output    out        o_valid / i_stall   o_symbol, o_kind
// config    in         APB write, pready=1 node_limit at byte address 0
//
// One bit per cycle sustained while i_stall is not holding the result register; an accepted
// beat is taken from the input queue by the back end, and any result it yields goes to the output register.
// Decode does one node-table lookup per bit, with both children's entries
// prefetched from two copies of the node table so the walk never waits.
// Synchronous active-low reset; node table and parent stack are not cleared.
// i_stall holds the result register; the two-beat input queue keeps taking beats until full.

module huffman_tree_load_and_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_data_bit,
    input  logic                            i_new_tree,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [hufd_pkg::SYM_BITS-1:0]   o_symbol,
    output logic [1:0]                      o_kind,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hufd_pkg::PADDR_W-1:0]    paddr,
    input  logic [hufd_pkg::PDATA_W-1:0]    pwdata,
    output logic [hufd_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic [hufd_pkg::LIMIT_W-1:0]    r_node_limit;
    logic [hufd_pkg::REG_IDX_W-1:0]  reg_idx;
    hufd_pkg::t_item                 item;
    hufd_pkg::t_head                 head;
    hufd_pkg::t_result               res;
    logic                            pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[hufd_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_limit <= hufd_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == hufd_pkg::REG_NODE_LIMIT)) begin
            r_node_limit <= pwdata[hufd_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = (reg_idx == hufd_pkg::REG_NODE_LIMIT)
                  ? hufd_pkg::PDATA_W'(r_node_limit) : '0;

    assign item.data_bit = i_data_bit;
    assign item.new_tree = i_new_tree;

    hufd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (item),
        .o_head  (head),
        .i_pop   (pop)
    );

    hufd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_node_limit (r_node_limit),
        .i_out_stall  (i_stall),
        .o_valid      (o_valid),
        .o_res        (res)
    );

    assign o_symbol = res.symbol;
    assign o_kind   = res.kind;

endmodule

`default_nettype wire

// ----- src/hufd_ram.sv -----
`default_nettype none

module hufd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 255
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/hufd_front.sv -----
`default_nettype none

module hufd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  hufd_pkg::t_item      i_item,
    output hufd_pkg::t_head      o_head,
    input  logic                 i_pop
);

    hufd_pkg::t_item                  r_slot [hufd_pkg::QDEPTH];
    logic [hufd_pkg::QPTR_W-1:0]      r_wptr;
    logic [hufd_pkg::QPTR_W-1:0]      r_rptr;
    logic [hufd_pkg::QCNT_W-1:0]      r_count;
    logic                             full;
    logic                             push;
    logic                             pop;

    assign full  = (r_count == hufd_pkg::QCNT_W'(hufd_pkg::QDEPTH));
    assign push  = i_valid && !full;
    assign pop   = i_pop && (r_count != '0);

    assign o_stall          = full;
    assign o_head.valid     = (r_count != '0);
    assign o_head.item      = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + hufd_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + hufd_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + hufd_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - hufd_pkg::QCNT_W'(1);
            end
        end
        if (push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/hufd_back.sv -----
`default_nettype none

module hufd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hufd_pkg::t_head               i_head,
    output logic                          o_pop,
    input  logic [hufd_pkg::LIMIT_W-1:0]  i_node_limit,
    input  logic                          i_out_stall,
    output logic                          o_valid,
    output hufd_pkg::t_result             o_res
);

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_PAD,
        PH_DECODE,
        PH_BAD
    } t_phase;

    t_phase                              r_phase,     n_phase,     e_phase;
    logic [hufd_pkg::BL_W-1:0]           r_bits_left, n_bits_left, e_bits_left;
    logic [hufd_pkg::SYM_BITS-1:0]       r_shift,     n_shift,     e_shift;
    logic [hufd_pkg::ALIGN_W-1:0]        r_hphase,    n_hphase,    e_hphase;
    logic [hufd_pkg::USED_W-1:0]         r_used,      n_used,      e_used;
    logic [hufd_pkg::CNT_W-1:0]          r_built,     n_built,     e_built;
    logic [hufd_pkg::CNT_W-1:0]          r_level,     n_level,     e_level;
    hufd_pkg::t_ref                      r_root_leaf, n_root_leaf, e_root_leaf;
    hufd_pkg::t_stk                      r_top,       n_top;
    hufd_pkg::t_stk                      r_below,     n_below;
    hufd_pkg::t_stk                      r_byp,       n_byp;
    logic                                r_byp_vld,   n_byp_vld;
    hufd_pkg::t_entry                    r_root,      n_root;
    hufd_pkg::t_entry                    r_cur,       n_cur;
    logic                                r_ovalid,    n_ovalid;
    hufd_pkg::t_result                   r_res,       n_res;

    logic                                go;
    logic                                restart;
    logic                                bit_in;
    logic                                p_req;
    hufd_pkg::t_ref                      p_ref;
    logic                                bad;
    logic                                done;
    logic [hufd_pkg::CNT_W-1:0]          pl_level;
    hufd_pkg::t_stk                      third;
    logic                                emit;
    hufd_pkg::t_result                   res;
    logic                                dec_step;
    hufd_pkg::t_entry                    dec_next;
    hufd_pkg::t_ref                      child;

    logic                                tab_we;
    logic [hufd_pkg::NODE_W-1:0]         tab_waddr;
    hufd_pkg::t_entry                    tab_wdata;
    logic [hufd_pkg::NODE_W-1:0]         tab_raddr0;
    logic [hufd_pkg::NODE_W-1:0]         tab_raddr1;
    hufd_pkg::t_entry                    kid0;
    hufd_pkg::t_entry                    kid1;

    logic                                stk_we;
    logic [hufd_pkg::CNT_W-1:0]          stk_wlvl;
    logic [hufd_pkg::CNT_W-1:0]          stk_rlvl;
    hufd_pkg::t_stk                      stk_wdata;
    hufd_pkg::t_stk                      stk_rdata;

    hufd_ram #(
        .WIDTH ($bits(hufd_pkg::t_entry)),
        .DEPTH (hufd_pkg::MAX_NODES)
    ) u_tab0 (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr0),
        .o_rdata (kid0)
    );

    hufd_ram #(
        .WIDTH ($bits(hufd_pkg::t_entry)),
        .DEPTH (hufd_pkg::MAX_NODES)
    ) u_tab1 (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr1),
        .o_rdata (kid1)
    );

    hufd_ram #(
        .WIDTH ($bits(hufd_pkg::t_stk)),
        .DEPTH (hufd_pkg::MAX_NODES)
    ) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_wlvl[hufd_pkg::NODE_W-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (stk_rlvl[hufd_pkg::NODE_W-1:0]),
        .o_rdata (stk_rdata)
    );

    assign go      = i_head.valid && (!r_ovalid || !i_out_stall);
    assign restart = go && i_head.item.new_tree;
    assign bit_in  = i_head.item.data_bit;
    assign o_pop   = go;
    assign third   = r_byp_vld ? r_byp : stk_rdata;

    always_comb begin
        e_phase     = restart ? PH_LOAD : r_phase;
        e_bits_left = restart ? '0 : r_bits_left;
        e_shift     = restart ? '0 : r_shift;
        e_hphase    = restart ? '0 : r_hphase;
        e_used      = restart ? '0 : r_used;
        e_built     = restart ? '0 : r_built;
        e_level     = restart ? '0 : r_level;
        e_root_leaf = restart ? '0 : r_root_leaf;

        n_phase     = e_phase;
        n_bits_left = e_bits_left;
        n_shift     = e_shift;
        n_hphase    = e_hphase;
        n_used      = e_used;
        n_built     = e_built;
        n_level     = e_level;
        n_root_leaf = e_root_leaf;
        n_top       = r_top;
        n_below     = r_below;
        n_byp       = r_byp;
        n_byp_vld   = r_byp_vld;

        p_req     = 1'b0;
        p_ref     = '0;
        bad       = 1'b0;
        done      = 1'b0;
        pl_level  = e_level;
        emit      = 1'b0;
        res       = '{symbol: '0, kind: hufd_pkg::KIND_SYMBOL};
        dec_step  = 1'b0;
        dec_next  = r_cur;
        child     = '0;
        tab_we    = 1'b0;
        tab_waddr = r_top.idx;
        tab_wdata = '{c1: '0, c0: r_top.first};
        stk_we    = 1'b0;
        stk_wlvl  = '0;
        stk_wdata = r_below;

        if (go) begin
            case (e_phase)
                PH_LOAD: begin
                    n_hphase = e_hphase + hufd_pkg::ALIGN_W'(1);
                    if (e_bits_left != '0) begin
                        n_shift     = {e_shift[hufd_pkg::SYM_BITS-2:0], bit_in};
                        n_bits_left = e_bits_left - hufd_pkg::BL_W'(1);
                        if (e_bits_left == hufd_pkg::BL_W'(1)) begin
                            p_req = 1'b1;
                            p_ref = '{leaf: 1'b1, val: hufd_pkg::VAL_W'(n_shift)};
                        end
                    end else if (e_used >= i_node_limit) begin
                        bad = 1'b1;
                    end else begin
                        n_used = e_used + hufd_pkg::USED_W'(1);
                        if (bit_in) begin
                            n_shift     = '0;
                            n_bits_left = hufd_pkg::BL_W'(hufd_pkg::SYM_BITS);
                        end else if (e_built >= hufd_pkg::CNT_W'(hufd_pkg::MAX_NODES)) begin
                            bad = 1'b1;
                        end else begin
                            n_built = e_built + hufd_pkg::CNT_W'(1);
                            p_req   = 1'b1;
                            p_ref   = '{leaf: 1'b0, val: hufd_pkg::VAL_W'(e_built)};
                        end
                    end

                    if (p_req) begin
                        if (e_level == '0) begin
                            if (p_ref.leaf) begin
                                n_root_leaf = p_ref;
                            end
                        end else if (r_top.second) begin
                            // parent closes: write whole entry, drop it from the stack
                            tab_we    = 1'b1;
                            tab_wdata = '{c1: p_ref, c0: r_top.first};
                            pl_level  = e_level - hufd_pkg::CNT_W'(1);
                            n_top     = r_below;
                            n_below   = third;
                            n_byp_vld = 1'b0;
                        end else begin
                            n_top.first  = p_ref;
                            n_top.second = 1'b1;
                        end
                        if (!p_ref.leaf) begin
                            if (pl_level >= hufd_pkg::CNT_W'(hufd_pkg::MAX_NODES)) begin
                                bad = 1'b1;
                            end else begin
                                if (pl_level >= hufd_pkg::CNT_W'(2)) begin
                                    stk_we = 1'b1;
                                end
                                stk_wlvl  = pl_level - hufd_pkg::CNT_W'(2);
                                stk_wdata = n_below;
                                n_byp     = n_below;
                                n_byp_vld = 1'b1;
                                n_below   = n_top;
                                n_top     = '{idx:    p_ref.val[hufd_pkg::NODE_W-1:0],
                                              second: 1'b0,
                                              first:  '0};
                                pl_level  = pl_level + hufd_pkg::CNT_W'(1);
                            end
                        end
                        n_level = pl_level;
                        done    = !bad && (pl_level == '0);
                    end

                    if (bad) begin
                        n_phase = PH_BAD;
                        emit    = 1'b1;
                        res     = '{symbol: '0, kind: hufd_pkg::KIND_BAD};
                    end else if (done) begin
                        n_phase = (n_hphase == '0) ? PH_DECODE : PH_PAD;
                        emit    = 1'b1;
                        res     = '{symbol: '0, kind: hufd_pkg::KIND_DONE};
                    end
                end
                PH_PAD: begin
                    n_hphase = e_hphase + hufd_pkg::ALIGN_W'(1);
                    if (n_hphase == '0) begin
                        n_phase = PH_DECODE;
                    end
                end
                PH_DECODE: begin
                    if (e_root_leaf.leaf) begin
                        emit = 1'b1;
                        res  = '{symbol: e_root_leaf.val[hufd_pkg::SYM_BITS-1:0],
                                 kind:   hufd_pkg::KIND_SYMBOL};
                    end else begin
                        dec_step = 1'b1;
                        child    = bit_in ? r_cur.c1 : r_cur.c0;
                        if (child.leaf) begin
                            emit     = 1'b1;
                            res      = '{symbol: child.val[hufd_pkg::SYM_BITS-1:0],
                                         kind:   hufd_pkg::KIND_SYMBOL};
                            dec_next = r_root;
                        end else begin
                            dec_next = bit_in ? kid1 : kid0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        n_root = (tab_we && (tab_waddr == '0)) ? tab_wdata : r_root;
        if (dec_step) begin
            n_cur = dec_next;
        end else if (e_phase == PH_DECODE) begin
            n_cur = r_cur;
        end else begin
            n_cur = n_root;
        end

        // prefetch the entries of both children of the next node
        tab_raddr0 = n_cur.c0.val[hufd_pkg::NODE_W-1:0];
        tab_raddr1 = n_cur.c1.val[hufd_pkg::NODE_W-1:0];
        stk_rlvl   = n_level - hufd_pkg::CNT_W'(3);

        if (go && emit) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
        n_res = (go && emit) ? res : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_LOAD;
            r_bits_left      <= '0;
            r_hphase         <= '0;
            r_used           <= '0;
            r_built          <= '0;
            r_level          <= '0;
            r_root_leaf.leaf <= 1'b0;
            r_byp_vld        <= 1'b0;
            r_ovalid         <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_bits_left      <= n_bits_left;
            r_hphase         <= n_hphase;
            r_used           <= n_used;
            r_built          <= n_built;
            r_level          <= n_level;
            r_root_leaf.leaf <= n_root_leaf.leaf;
            r_byp_vld        <= n_byp_vld;
            r_ovalid         <= n_ovalid;
        end
        r_shift         <= n_shift;
        r_root_leaf.val <= n_root_leaf.val;
        r_top           <= n_top;
        r_below         <= n_below;
        r_byp           <= n_byp;
        r_root          <= n_root;
        r_cur           <= n_cur;
        r_res           <= n_res;
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

endmodule

`default_nettype wire
